@@ hdl/tdts_pkg.sv @@
// Package: character classes, scanner states, token kinds and result type.
package tdts_pkg;

    localparam int TEXT_BUFFER_DEF = 9;
    localparam int CharMax = 8;

    typedef enum logic [3:0] {
        C_WS = 4'd0, C_DIG = 4'd1, C_LET = 4'd2, C_SGN = 4'd3, C_OPR = 4'd4,
        C_LT = 4'd5, C_GT = 4'd6, C_COL = 4'd7, C_EQ = 4'd8, C_SEMI = 4'd9,
        C_PAR = 4'd10, C_EOF = 4'd11, C_UNK = 4'd12
    } cls_t;

    typedef enum logic [17:0] {
        S_START  = 18'h00001, S_LIT   = 18'h00002, S_WORD  = 18'h00004,
        S_SIGN   = 18'h00008, S_OPR   = 18'h00010, S_EQ    = 18'h00020,
        S_NEQ    = 18'h00040, S_LT    = 18'h00080, S_LTE   = 18'h00100,
        S_GT     = 18'h00200, S_GTE   = 18'h00400, S_COLON = 18'h00800,
        S_ASSIGN = 18'h01000, S_SEMI  = 18'h02000, S_PAREN = 18'h04000,
        S_ERR    = 18'h08000, S_ACC   = 18'h10000, S_END   = 18'h20000
    } st_t;

    localparam logic [4:0] K_LIT    = 5'd0;
    localparam logic [4:0] K_IDENT  = 5'd1;
    localparam logic [4:0] K_VAR    = 5'd2;
    localparam logic [4:0] K_BEGIN  = 5'd3;
    localparam logic [4:0] K_END    = 5'd4;
    localparam logic [4:0] K_INT    = 5'd5;
    localparam logic [4:0] K_READ   = 5'd6;
    localparam logic [4:0] K_WRITE  = 5'd7;
    localparam logic [4:0] K_IF     = 5'd8;
    localparam logic [4:0] K_ELSE   = 5'd9;
    localparam logic [4:0] K_WHILE  = 5'd10;
    localparam logic [4:0] K_PLUS   = 5'd11;
    localparam logic [4:0] K_MINUS  = 5'd12;
    localparam logic [4:0] K_MUL    = 5'd13;
    localparam logic [4:0] K_DIV    = 5'd14;
    localparam logic [4:0] K_EQ     = 5'd15;
    localparam logic [4:0] K_NEQ    = 5'd16;
    localparam logic [4:0] K_LT     = 5'd17;
    localparam logic [4:0] K_LTE    = 5'd18;
    localparam logic [4:0] K_GT     = 5'd19;
    localparam logic [4:0] K_GTE    = 5'd20;
    localparam logic [4:0] K_COLON  = 5'd21;
    localparam logic [4:0] K_ASSIGN = 5'd22;
    localparam logic [4:0] K_SEMI   = 5'd23;
    localparam logic [4:0] K_LPAR   = 5'd24;
    localparam logic [4:0] K_RPAR   = 5'd25;
    localparam logic [4:0] K_EOI    = 5'd26;
    localparam logic [4:0] K_INV    = 5'd27;
    localparam logic [4:0] K_LONG   = 5'd28;

    // Result item as it leaves the scanner
    typedef struct packed {
        logic [4:0]         kind;
        logic [15:0]        row;
        logic [15:0]        col;
        logic signed [27:0] value;
        logic [63:0]        chars;
        logic [3:0]         len;
        logic               last;
    } res_t;

    localparam int ResW = $bits(res_t);

    // Keyword texts, first char in lowest byte
    function automatic logic [4:0] kw_match(input logic [63:0] t, input logic [3:0] n);
        logic [4:0] k;
        k = K_IDENT;
        if (n == 4'd3 && t[23:0] == 24'h726176) k = K_VAR;
        if (n == 4'd5 && t[39:0] == 40'h6E69676562) k = K_BEGIN;
        if (n == 4'd3 && t[23:0] == 24'h646E65) k = K_END;
        if (n == 4'd3 && t[23:0] == 24'h746E69) k = K_INT;
        if (n == 4'd4 && t[31:0] == 32'h64616572) k = K_READ;
        if (n == 4'd5 && t[39:0] == 40'h6574697277) k = K_WRITE;
        if (n == 4'd2 && t[15:0] == 16'h6669) k = K_IF;
        if (n == 4'd4 && t[31:0] == 32'h65736C65) k = K_ELSE;
        if (n == 4'd5 && t[39:0] == 40'h656C696877) k = K_WHILE;
        return k;
    endfunction

    function automatic cls_t class_of(input logic [7:0] c);
        cls_t r;
        r = C_UNK;
        if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D) r = C_WS;
        else if (c >= 8'h30 && c <= 8'h39) r = C_DIG;
        else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) r = C_LET;
        else if (c == 8'h2B || c == 8'h2D) r = C_SGN;
        else if (c == 8'h2A || c == 8'h2F) r = C_OPR;
        else if (c == 8'h3C) r = C_LT;
        else if (c == 8'h3E) r = C_GT;
        else if (c == 8'h3A) r = C_COL;
        else if (c == 8'h3D) r = C_EQ;
        else if (c == 8'h3B) r = C_SEMI;
        else if (c == 8'h28 || c == 8'h29) r = C_PAR;
        return r;
    endfunction

    // Transition table
    function automatic st_t next_of(input st_t s, input cls_t c);
        st_t n;
        n = S_ACC;
        if (c == C_UNK) n = S_ERR;
        else begin
            case (s)
                S_START:
                begin
                    case (c)
                        C_WS: n = S_START;
                        C_DIG: n = S_LIT;
                        C_LET: n = S_WORD;
                        C_SGN: n = S_SIGN;
                        C_OPR: n = S_OPR;
                        C_LT: n = S_LT;
                        C_GT: n = S_GT;
                        C_COL: n = S_COLON;
                        C_EQ: n = S_EQ;
                        C_SEMI: n = S_SEMI;
                        C_PAR: n = S_PAREN;
                        C_EOF: n = S_END;
                        default: n = S_ERR;
                    endcase
                end
                S_LIT: if (c == C_DIG) n = S_LIT; else if (c == C_LET) n = S_ERR;
                S_WORD:
                begin
                    if (c == C_DIG || c == C_LET) n = S_WORD;
                    else if (c == C_SGN || c == C_OPR) n = S_ERR;
                end
                S_SIGN: if (c == C_DIG) n = S_LIT;
                S_LT:
                begin
                    if (c == C_LT) n = S_ERR;
                    else if (c == C_GT) n = S_NEQ;
                    else if (c == C_EQ) n = S_LTE;
                end
                S_LTE, S_GTE: if (c == C_LT || c == C_GT) n = S_ERR;
                S_GT:
                begin
                    if (c == C_LT || c == C_GT) n = S_ERR;
                    else if (c == C_EQ) n = S_GTE;
                end
                S_COLON: if (c == C_EQ) n = S_ASSIGN;
                S_ASSIGN, S_SEMI: if (c == C_EQ) n = S_ERR;
                default: n = S_ACC;
            endcase
        end
        return n;
    endfunction

endpackage

@@ hdl/tdts_front.sv @@
// Front: classify bytes, step the transition table, build result requests.
module tdts_front #(
    parameter int TEXT_BUFFER = tdts_pkg::TEXT_BUFFER_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_char,
    input  logic                in_eoi,
    output logic                q_push,
    output logic [1:0]          q_cnt,
    output tdts_pkg::res_t      q_a,
    output tdts_pkg::res_t      q_b,
    input  logic [1:0]          q_space
);
    import tdts_pkg::*;

    // Text count wide enough for any text limit up to 15
    localparam int CW = 4;

    st_t                st_reg;
    logic [63:0]        txt_reg;
    logic [CW-1:0]      cnt_reg;
    logic [27:0]        acc_reg;
    logic [15:0]        trow_reg, tcol_reg, crow_reg, ccol_reg;

    st_t                st_next;
    logic [63:0]        txt_next;
    logic [CW-1:0]      cnt_next;
    logic [27:0]        acc_next;
    logic [15:0]        trow_next, tcol_next, crow_next, ccol_next;
    logic [1:0]         n_res;
    res_t               r0, r1;

    function automatic logic [63:0] masked(input logic [63:0] t, input logic [CW-1:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < CharMax; i++)
            if (CW'(i) < n) m[8*i +: 8] = 8'hFF;
        return t & m;
    endfunction

    function automatic res_t mk(input logic [4:0] k, input logic [15:0] rw,
                                input logic [15:0] cl, input logic [27:0] v,
                                input logic [63:0] ch, input logic [CW-1:0] n);
        res_t r;
        r.kind = k; r.row = rw; r.col = cl; r.value = v; r.chars = ch;
        r.len = 4'(n); r.last = 1'b0;
        return r;
    endfunction

    // Accept when the queue can take the worst case of two results
    assign in_ready = (q_space == 2'd2);
    assign q_push = in_valid && in_ready && (n_res != 2'd0);
    assign q_cnt = n_res;
    assign q_a = r0;
    assign q_b = r1;

    // Step the scanner, at most two passes per byte
    always_comb
    begin
        cls_t        cls;
        logic        nl, done, adv;
        st_t         s, ns;
        logic [4:0]  kind;
        logic [27:0] val;
        res_t        rr;
        cls = in_eoi ? C_EOF : class_of(in_char);
        nl = !in_eoi && in_char == 8'h0A;
        st_next = st_reg; txt_next = txt_reg; cnt_next = cnt_reg; acc_next = acc_reg;
        trow_next = trow_reg; tcol_next = tcol_reg; crow_next = crow_reg;
        ccol_next = ccol_reg;
        n_res = 2'd0; r0 = '0; r1 = '0; done = 1'b0; adv = 1'b0;
        s = S_START; ns = S_START; kind = K_IDENT; val = '0;
        for (int p = 0; p < 3; p++) begin
            rr = '0;
            if (!done) begin
                s = (st_next inside {S_ACC, S_END}) ? S_START : st_next;
                ns = next_of(s, cls);
                if (s == S_START && ns == S_END) begin
                    rr = mk(K_EOI, crow_next, ccol_next, '0, '0, '0);
                    if (n_res == 2'd0) r0 = rr; else r1 = rr;
                    n_res = n_res + 2'd1; done = 1'b1;
                end else if ((s == S_ERR && ns != S_ERR) ||
                             (s != S_START && ns == S_ACC && cnt_next >= CW'(TEXT_BUFFER))) begin
                    if (cnt_next < CW'(TEXT_BUFFER) && s == S_ERR)
                        rr = mk(K_INV, trow_next, tcol_next, '0,
                                masked(txt_next, cnt_next), cnt_next);
                    else
                        rr = mk(K_LONG, trow_next, tcol_next, '0, '0, '0);
                    if (n_res == 2'd0) r0 = rr; else r1 = rr;
                    n_res = n_res + 2'd1;
                    cnt_next = '0; acc_next = '0; st_next = S_START;
                    adv = 1'b1;
                    if (!in_eoi) done = 1'b1;
                end else if (s != S_START && ns == S_ACC) begin
                    val = '0;
                    case (s)
                        S_LIT:
                        begin
                            kind = K_LIT;
                            val = (txt_next[7:0] == 8'h2D) ? (28'd0 - acc_next) : acc_next;
                        end
                        S_WORD: kind = kw_match(masked(txt_next, cnt_next), 4'(cnt_next));
                        S_SIGN: kind = (txt_next[7:0] == 8'h2B) ? K_PLUS : K_MINUS;
                        S_OPR: kind = (txt_next[7:0] == 8'h2A) ? K_MUL : K_DIV;
                        S_PAREN: kind = (txt_next[7:0] == 8'h28) ? K_LPAR : K_RPAR;
                        S_EQ: kind = K_EQ;
                        S_NEQ: kind = K_NEQ;
                        S_LT: kind = K_LT;
                        S_LTE: kind = K_LTE;
                        S_GT: kind = K_GT;
                        S_GTE: kind = K_GTE;
                        S_COLON: kind = K_COLON;
                        S_ASSIGN: kind = K_ASSIGN;
                        // remaining accepting state is the semicolon
                        default: kind = K_SEMI;
                    endcase
                    rr = mk(kind, trow_next, tcol_next, val,
                            masked(txt_next, cnt_next), cnt_next);
                    if (n_res == 2'd0) r0 = rr; else r1 = rr;
                    n_res = n_res + 2'd1;
                    cnt_next = '0; acc_next = '0; st_next = S_START;
                end else begin
                    if (s == S_START && ns != S_START) begin
                        trow_next = crow_next; tcol_next = ccol_next;
                        cnt_next = '0; acc_next = '0;
                    end
                    st_next = ns;
                    if (ns != S_START && cnt_next < CW'(TEXT_BUFFER)) begin
                        if (cnt_next < CW'(CharMax))
                            txt_next[8*cnt_next[2:0] +: 8] = in_char;
                        cnt_next = cnt_next + CW'(1);
                        if (ns == S_LIT && cls == C_DIG)
                            acc_next = 28'((acc_next * 28'd10) + 28'(in_char - 8'h30));
                    end
                    adv = 1'b1; done = 1'b1;
                end
                if (adv) begin
                    adv = 1'b0;
                    if (nl) begin
                        if (crow_next != 16'hFFFF) crow_next = crow_next + 16'd1;
                        ccol_next = 16'd1;
                    end else if (ccol_next != 16'hFFFF) ccol_next = ccol_next + 16'd1;
                end
            end
        end
        if (n_res == 2'd1) r0.last = 1'b1;
        if (n_res == 2'd2) r1.last = 1'b1;
    end

    // Commit state on an accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= S_START; cnt_reg <= '0; acc_reg <= '0;
            trow_reg <= 16'd1; tcol_reg <= 16'd1; crow_reg <= 16'd1; ccol_reg <= 16'd1;
        end else if (in_valid && in_ready) begin
            st_reg <= st_next; cnt_reg <= cnt_next; acc_reg <= acc_next;
            trow_reg <= trow_next; tcol_reg <= tcol_next;
            crow_reg <= crow_next; ccol_reg <= ccol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) txt_reg <= txt_next;
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(TEXT_BUFFER)) else $error("text count overflow");
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> in_ready) else $error("push without room");
    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        crow_reg != 16'd0 && ccol_reg != 16'd0) else $error("cursor zero");
`endif
endmodule

@@ hdl/tdts_back.sv @@
// Back: result queue of four entries feeding the output stream.
module tdts_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_push,
    input  logic [1:0]          q_cnt,
    input  tdts_pkg::res_t      q_a,
    input  tdts_pkg::res_t      q_b,
    output logic [1:0]          q_space,
    output logic                out_valid,
    input  logic                out_ready,
    output tdts_pkg::res_t      out_res
);
    import tdts_pkg::*;

    res_t        mem_reg [4];
    logic [1:0]  wp_reg, rp_reg;
    logic [2:0]  cnt_reg;
    logic        pop;
    logic [2:0]  nin;

    assign out_valid = (cnt_reg != 3'd0);
    assign out_res = mem_reg[rp_reg];
    assign pop = out_valid && out_ready;
    assign nin = q_push ? {1'b0, q_cnt} : 3'd0;
    // Room for two counts a pop in the same cycle
    assign q_space = (cnt_reg <= 3'd2 || (cnt_reg == 3'd3 && out_ready)) ? 2'd2 : 2'd0;

    // Write one or two requests, advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            wp_reg <= wp_reg + nin[1:0];
            if (pop) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + nin - {2'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push) begin
            mem_reg[wp_reg] <= q_a;
            if (q_cnt == 2'd2) mem_reg[wp_reg + 2'd1] <= q_b;
        end
    end

`ifndef SYNTHESIS
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4) else $error("queue overflow");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_res.kind <= K_LONG) else $error("bad kind");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result lost");
`endif
endmodule

@@ hdl/table_driven_token_scanner.sv @@
// Top level: token scanner with a decoupled result queue.
//  channel | dir | handshake                  | payload
//  s_axis  | in  | s_axis_tvalid/tready       | tdata next_char, tuser end_of_input
//  m_axis  | out | m_axis_tvalid/tready       | tdata token fields, tlast last_of_run
// One byte per cycle is accepted; the two-pass transition step is combinational.
// Input stalls unless the four-entry result queue has two free slots, counting a
// result that leaves in the same cycle.
// Reset (rst_n low, asynchronous) returns the scanner to the start state, cursor 1,1.
module table_driven_token_scanner #(
    parameter int TEXT_BUFFER = tdts_pkg::TEXT_BUFFER_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // next_char
    input  logic         s_axis_tuser,   // end_of_input
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // token_kind[4:0] start_row[20:5] start_col[36:21] literal_value[64:37]
    // token_chars[128:65] token_length[132:129], zero to 135
    output logic [135:0] m_axis_tdata,
    output logic         m_axis_tlast    // last_of_run
);
    import tdts_pkg::*;

    logic       q_push;
    logic [1:0] q_cnt, q_space;
    res_t       q_a, q_b, o;

    tdts_front #(.TEXT_BUFFER(TEXT_BUFFER)) u_front (
        .clk, .rst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_char(s_axis_tdata), .in_eoi(s_axis_tuser), .q_push, .q_cnt,
        .q_a, .q_b, .q_space);

    tdts_back u_back (
        .clk, .rst_n, .q_push, .q_cnt, .q_a, .q_b, .q_space,
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(o));

    assign m_axis_tdata = {3'b0, o.len, o.chars, o.value, o.col, o.row, o.kind};
    assign m_axis_tlast = o.last;
endmodule
